// ----- sv/rtc_pkg.sv -----
// Package for the radio tuning command decoder: mode, action and status
// codes, command characters, tuning limits, reset values, register word pieces and the result item type.
// No dependencies.
package rtc_pkg;

   // Receiver modes
   typedef enum logic [2:0] {
      MODE_STOPPED = 3'd0,
      MODE_RUNNING = 3'd1,
      MODE_GAIN    = 3'd2,
      MODE_INT     = 3'd3,
      MODE_FRAC    = 3'd4,
      MODE_AFC     = 3'd5
   } mode_type;

   // Action codes
   typedef enum logic [2:0] {
      ACT_NONE       = 3'd0,
      ACT_START      = 3'd1,
      ACT_STOP       = 3'd2,
      ACT_SCAN       = 3'd3,
      ACT_DUMP_IQ    = 3'd4,
      ACT_DUMP_AUDIO = 3'd5,
      ACT_REG        = 3'd6,
      ACT_CHANNEL    = 3'd7
   } action_type;

   // Status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NOT_STARTED = 3'd1,
      ST_NO_MODE     = 3'd2,
      ST_LIMIT       = 3'd3,
      ST_UNKNOWN     = 3'd4
   } status_type;

   // Command characters
   localparam logic [7:0] CMD_START      = 8'h41; // 'A'
   localparam logic [7:0] CMD_STOP       = 8'h42; // 'B'
   localparam logic [7:0] CMD_SCAN       = 8'h43; // 'C'
   localparam logic [7:0] CMD_DUMP_IQ    = 8'h55; // 'U'
   localparam logic [7:0] CMD_DUMP_AUDIO = 8'h75; // 'u'
   localparam logic [7:0] CMD_ADJ_GAIN   = 8'h47; // 'G'
   localparam logic [7:0] CMD_ADJ_INT    = 8'h49; // 'I'
   localparam logic [7:0] CMD_ADJ_FRAC   = 8'h46; // 'F'
   localparam logic [7:0] CMD_ADJ_AFC    = 8'h66; // 'f'
   localparam logic [7:0] CMD_PLUS       = 8'h2B; // '+'
   localparam logic [7:0] CMD_MINUS      = 8'h2D; // '-'
   localparam logic [7:0] CMD_DIGIT_0    = 8'h30; // '0'
   localparam logic [7:0] CMD_DIGIT_1    = 8'h31; // '1'
   localparam logic [7:0] CMD_DIGIT_9    = 8'h39; // '9'

   // Tuning limits and steps
   localparam logic [5:0]  GAIN_MAX      = 6'd63;
   localparam logic [5:0]  INT_MAX       = 6'd36;
   localparam logic [5:0]  INT_MIN       = 6'd29;
   localparam logic [11:0] FRAC_UP_LIMIT = 12'd2980;
   localparam logic [11:0] FRAC_STEP     = 12'd10;
   localparam logic [11:0] AFC_UP_LIMIT  = 12'd3900;
   localparam logic [11:0] AFC_STEP      = 12'd100;

   // Reset values
   localparam logic [5:0]  GAIN_RESET = 6'd20;
   localparam logic [5:0]  INT_RESET  = 6'd31;
   localparam logic [11:0] FRAC_RESET = 12'd400;
   localparam logic [11:0] AFC_RESET  = 12'd0;

   // Register word pieces
   localparam logic [21:0] GAIN_BASE_WORD = 22'h016001;
   localparam logic [3:0]  SYNTH_TAG      = 4'd2;
   localparam logic [3:0]  AFC_TAG        = 4'd3;

   // Result item
   typedef struct packed {
      action_type  action;
      status_type  status;
      logic [21:0] reg_word;
      logic [3:0]  channel_index;
      mode_type    mode_now;
      logic [5:0]  gain_now;
      logic [5:0]  int_now;
      logic [11:0] frac_now;
      logic [11:0] afc_now;
   } result_type;

endpackage

// ----- sv/rtc_if.sv -----
// Handshake channels of the radio tuning command decoder: command bytes in,
// result items out. No dependencies.
interface rtc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cmd_byte;

   modport source (output valid, output cmd_byte, input ready);
   modport sink   (input valid, input cmd_byte, output ready);
endinterface

interface rtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [2:0]  status;
   logic [21:0] reg_word;
   logic [3:0]  channel_index;
   logic [2:0]  mode_now;
   logic [5:0]  gain_now;
   logic [5:0]  int_now;
   logic [11:0] frac_now;
   logic [11:0] afc_now;

   modport source (output valid, output action, output status, output reg_word,
                   output channel_index, output mode_now, output gain_now,
                   output int_now, output frac_now, output afc_now, input ready);
   modport sink   (input valid, input action, input status, input reg_word,
                   input channel_index, input mode_now, input gain_now,
                   input int_now, input frac_now, input afc_now, output ready);
endinterface

// ----- sv/radio_tuning_command_fsm.sv -----
// Radio tuning command decoder: console command bytes in, one result item
// per byte out. Depends on rtc_pkg and the channels in rtc_if.
//
//   channel   direction  payload                               handshake
//   req_if    in         cmd_byte[7:0]                         valid/ready
//   rsp_if    out        action, status, reg_word, channel,    valid/ready
//                        mode and the four tuning values
//
// Each item is decoded against the mode and tuning registers in the cycle
// it is accepted; its result sits in the output register from the next
// cycle on, and one item is taken per cycle while the output keeps draining.
// A new item is taken while the output register is empty or being drained.
// Synchronous reset sets mode stopped, gain 20, int 31, frac 400, afc 0.
module radio_tuning_command_fsm (
   input  logic          clock,
   input  logic          reset,
   rtc_req_if.sink       req_if,
   rtc_rsp_if.source     rsp_if
);

   rtc_pkg::mode_type   mode_ff, mode_in;
   logic [5:0]          gain_ff, gain_in;
   logic [5:0]          int_ff, int_in;
   logic [11:0]         frac_ff, frac_in;
   logic [11:0]         afc_ff, afc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rtc_pkg::result_type rsp_ff, rsp_in;

   logic                accept;
   logic [7:0]          cmd;
   logic                is_digit;
   logic                is_step;
   logic                step_up;
   logic                step_ok;

   // Accept whenever the output register frees up this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign cmd          = req_if.cmd_byte;
   assign is_digit     = (cmd >= rtc_pkg::CMD_DIGIT_0) && (cmd <= rtc_pkg::CMD_DIGIT_9);
   assign is_step      = (cmd == rtc_pkg::CMD_PLUS) || (cmd == rtc_pkg::CMD_MINUS);
   assign step_up      = (cmd == rtc_pkg::CMD_PLUS);

   // Check whether a step in the current adjust mode stays inside its limits
   always_comb begin
      case (mode_ff)
         rtc_pkg::MODE_GAIN: step_ok = step_up ? (gain_ff != 6'd0)
                                               : (gain_ff < rtc_pkg::GAIN_MAX);
         rtc_pkg::MODE_INT:  step_ok = step_up ? (int_ff < rtc_pkg::INT_MAX)
                                               : (int_ff > rtc_pkg::INT_MIN);
         rtc_pkg::MODE_FRAC: step_ok = step_up ? (frac_ff <= rtc_pkg::FRAC_UP_LIMIT)
                                               : (frac_ff >= rtc_pkg::FRAC_STEP);
         rtc_pkg::MODE_AFC:  step_ok = step_up ? (afc_ff <= rtc_pkg::AFC_UP_LIMIT)
                                               : (afc_ff >= rtc_pkg::AFC_STEP);
         default:            step_ok = 1'b0;
      endcase
   end

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         case (cmd)
            rtc_pkg::CMD_START: mode_in = rtc_pkg::MODE_RUNNING;
            rtc_pkg::CMD_STOP:  mode_in = rtc_pkg::MODE_STOPPED;
            rtc_pkg::CMD_ADJ_GAIN: begin
               if (mode_ff == rtc_pkg::MODE_RUNNING) mode_in = rtc_pkg::MODE_GAIN;
            end
            rtc_pkg::CMD_ADJ_INT: begin
               if (mode_ff == rtc_pkg::MODE_RUNNING) mode_in = rtc_pkg::MODE_INT;
            end
            rtc_pkg::CMD_ADJ_FRAC: begin
               if (mode_ff == rtc_pkg::MODE_RUNNING) mode_in = rtc_pkg::MODE_FRAC;
            end
            rtc_pkg::CMD_ADJ_AFC: begin
               if (mode_ff == rtc_pkg::MODE_RUNNING) mode_in = rtc_pkg::MODE_AFC;
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Step the tuning values
   always_comb begin
      gain_in = gain_ff;
      int_in  = int_ff;
      frac_in = frac_ff;
      afc_in  = afc_ff;
      if (accept && is_step && step_ok) begin
         case (mode_ff)
            rtc_pkg::MODE_GAIN: gain_in = step_up ? gain_ff - 6'd1 : gain_ff + 6'd1;
            rtc_pkg::MODE_INT:  int_in  = step_up ? int_ff + 6'd1 : int_ff - 6'd1;
            rtc_pkg::MODE_FRAC: frac_in = step_up ? frac_ff + rtc_pkg::FRAC_STEP
                                                  : frac_ff - rtc_pkg::FRAC_STEP;
            rtc_pkg::MODE_AFC:  afc_in  = step_up ? afc_ff + rtc_pkg::AFC_STEP
                                                  : afc_ff - rtc_pkg::AFC_STEP;
            default: begin
               gain_in = gain_ff;
            end
         endcase
      end
   end

   // Build the result item from the command and the updated state
   always_comb begin
      rsp_in               = '0;
      rsp_in.action        = rtc_pkg::ACT_NONE;
      rsp_in.status        = rtc_pkg::ST_OK;
      rsp_in.mode_now      = mode_in;
      rsp_in.gain_now      = gain_in;
      rsp_in.int_now       = int_in;
      rsp_in.frac_now      = frac_in;
      rsp_in.afc_now       = afc_in;
      if (is_step) begin
         if (step_ok) begin
            rsp_in.action = rtc_pkg::ACT_REG;
            case (mode_ff)
               rtc_pkg::MODE_GAIN:
                  rsp_in.reg_word = rtc_pkg::GAIN_BASE_WORD + {12'd0, gain_in, 4'd0};
               rtc_pkg::MODE_AFC:
                  rsp_in.reg_word = {6'd0, afc_in, rtc_pkg::AFC_TAG};
               default:
                  rsp_in.reg_word = {int_in, frac_in, rtc_pkg::SYNTH_TAG};
            endcase
         end else if ((mode_ff == rtc_pkg::MODE_STOPPED)
                      || (mode_ff == rtc_pkg::MODE_RUNNING)) begin
            rsp_in.status = rtc_pkg::ST_NO_MODE;
         end else begin
            rsp_in.status = rtc_pkg::ST_LIMIT;
         end
      end else if (is_digit) begin
         rsp_in.action = rtc_pkg::ACT_CHANNEL;
         rsp_in.channel_index = (cmd == rtc_pkg::CMD_DIGIT_0) ? 4'd9
                                : 4'(cmd - rtc_pkg::CMD_DIGIT_1);
      end else begin
         case (cmd)
            rtc_pkg::CMD_START: rsp_in.action = rtc_pkg::ACT_START;
            rtc_pkg::CMD_STOP:  rsp_in.action = rtc_pkg::ACT_STOP;
            rtc_pkg::CMD_SCAN:  rsp_in.action = rtc_pkg::ACT_SCAN;
            rtc_pkg::CMD_DUMP_IQ, rtc_pkg::CMD_DUMP_AUDIO: begin
               if (mode_ff == rtc_pkg::MODE_RUNNING)
                  rsp_in.action = (cmd == rtc_pkg::CMD_DUMP_IQ) ? rtc_pkg::ACT_DUMP_IQ
                                                               : rtc_pkg::ACT_DUMP_AUDIO;
               else
                  rsp_in.status = rtc_pkg::ST_NOT_STARTED;
            end
            rtc_pkg::CMD_ADJ_GAIN, rtc_pkg::CMD_ADJ_INT,
            rtc_pkg::CMD_ADJ_FRAC, rtc_pkg::CMD_ADJ_AFC: begin
               if (mode_ff != rtc_pkg::MODE_RUNNING)
                  rsp_in.status = rtc_pkg::ST_NOT_STARTED;
            end
            default: rsp_in.status = rtc_pkg::ST_UNKNOWN;
         endcase
      end
   end

   // Output register occupancy: load on accept, drop when taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   // Control and tuning state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rtc_pkg::MODE_STOPPED;
         gain_ff      <= rtc_pkg::GAIN_RESET;
         int_ff       <= rtc_pkg::INT_RESET;
         frac_ff      <= rtc_pkg::FRAC_RESET;
         afc_ff       <= rtc_pkg::AFC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         afc_ff       <= afc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Drive the result channel
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.action        = rsp_ff.action;
   assign rsp_if.status        = rsp_ff.status;
   assign rsp_if.reg_word      = rsp_ff.reg_word;
   assign rsp_if.channel_index = rsp_ff.channel_index;
   assign rsp_if.mode_now      = rsp_ff.mode_now;
   assign rsp_if.gain_now      = rsp_ff.gain_now;
   assign rsp_if.int_now       = rsp_ff.int_now;
   assign rsp_if.frac_now      = rsp_ff.frac_now;
   assign rsp_if.afc_now       = rsp_ff.afc_now;

   // Start command always leaves the receiver running
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      accept && (cmd == rtc_pkg::CMD_START) |=> mode_ff == rtc_pkg::MODE_RUNNING)
      else $error("start command did not enter running mode");

   // A register write is only reported with ok status
   a_reg_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.action == rtc_pkg::ACT_REG) |-> rsp_ff.status == rtc_pkg::ST_OK)
      else $error("register write with non-ok status");

   // Integer divider stays inside its limits
   a_int_range: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (int_ff >= rtc_pkg::INT_MIN) && (int_ff <= rtc_pkg::INT_MAX))
      else $error("integer divider out of range");

   // A gain raise step lowers the gain setting by one
   a_gain_step: assert property (@(posedge clock) disable iff (reset)
      accept && (mode_ff == rtc_pkg::MODE_GAIN) && (cmd == rtc_pkg::CMD_PLUS)
      && (gain_ff != 6'd0) |=> gain_ff == $past(gain_ff) - 6'd1)
      else $error("gain step did not move by one");

   // The result register reflects the state left by the item it holds
   a_mode_echo: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.mode_now == mode_ff)
      else $error("reported mode differs from stored mode");

endmodule
